FILE: design/oahs_pkg.sv
`timescale 1ns / 1ps
package oahs_pkg;
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_MEMBER = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_MEMBER    = 3'd4;
    localparam logic [2:0] ST_RESERVED  = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;
    localparam logic [2:0] ST_CLEARED   = 3'd7;

    localparam int          COUNT_BITS       = 11;
    localparam int          KEY_BITS         = 48;
    localparam logic [10:0] LOAD_LIMIT_RESET = 11'd870;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [KEY_BITS-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] item_count;
    } out_item_t;

    // Command handed from the front end to the back end through the queue.
    typedef struct packed {
        logic [1:0]          opcode;
        logic                reserved;
        logic [KEY_BITS-1:0] key;
    } cmd_t;
endpackage

FILE: design/open_addressing_hash_set.sv
`timescale 1ns / 1ps
// Hash set of keys in a single-port table of SLOTS entries, probed from slot
// (73*key) mod SLOTS with stride 5009 mod SLOTS. Each probe is one memory read
// followed by one evaluation; clear and reset sweep the table one slot a
// cycle, during which the back end takes no command. A two-entry command queue
// lets input transfers proceed while the back end probes or a result waits.
module open_addressing_hash_set #(
    parameter int SLOTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  oahs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output oahs_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [10:0]         cfg_data
);
    import oahs_pkg::*;

    logic        cmd_valid, cmd_ready;
    cmd_t        cmd_data;
    logic [10:0] load_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_limit_reg <= LOAD_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            load_limit_reg <= cfg_data;
        end
    end

    oahs_front #(.DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
    );

    oahs_back #(.SLOTS(SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
        .load_limit(load_limit_reg),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule

FILE: design/oahs_front.sv
`timescale 1ns / 1ps
module oahs_front #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  oahs_pkg::in_item_t in_data,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output oahs_pkg::cmd_t   cmd_data
);
    import oahs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t            q_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     fill_reg;
    logic [KEY_BITS-1:0] key_m;
    cmd_t            cmd_in;
    logic            push, pop;

    always_comb
    begin
        key_m = in_data.key;
        cmd_in = '0;
        cmd_in.opcode = in_data.opcode;
        cmd_in.key = key_m;
        // Keys 0 and 1 mark empty and deleted slots and can never be stored.
        cmd_in.reserved = (key_m[KEY_BITS-1:1] == '0);
    end

    assign in_ready  = (fill_reg != (PW+1)'(DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd_data  = q_mem[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (PW+1)'(DEPTH))
        else $error("queue fill above depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == (PW+1)'(DEPTH)) && !pop |=> fill_reg == (PW+1)'(DEPTH))
        else $error("queue overflowed");
    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == '0 |-> !cmd_valid)
        else $error("pop from empty queue");
`endif
endmodule

FILE: design/oahs_back.sv
`timescale 1ns / 1ps
module oahs_back #(
    parameter int SLOTS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  oahs_pkg::cmd_t    cmd_data,
    input  logic [10:0]       load_limit,
    output logic              out_valid,
    input  logic              out_ready,
    output oahs_pkg::out_item_t out_data
);
    import oahs_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] STRIDE = AW'(5009 % SLOTS);
    localparam logic [AW-1:0] HOME_MUL = AW'(73);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [KEY_BITS-1:0] mem [SLOTS];
    logic [KEY_BITS-1:0] rdata_reg;

    logic [2:0]          state_reg;
    logic [AW-1:0]       idx_reg;
    logic [CW-1:0]       steps_reg;
    logic [CW-1:0]       live_reg, del_reg;
    logic [1:0]          op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [2:0]          st_reg;
    logic                out_valid_reg;
    logic [10:0]         cnt_out_reg;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic                is_empty, is_del, is_hit, last_step, at_limit;
    logic [CW:0]         used;

    assign cmd_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data.status = st_reg;
    assign out_data.item_count = cnt_out_reg;

    assign is_empty  = (rdata_reg == KEY_BITS'(0));
    assign is_del    = (rdata_reg == KEY_BITS'(1));
    assign is_hit    = (rdata_reg == key_reg);
    assign last_step = (steps_reg == CW'(SLOTS - 1));
    assign used      = {1'b0, live_reg} + {1'b0, del_reg};
    assign at_limit  = ((CW+1 > 11) ? used >= (CW+1)'(load_limit)
                                    : 12'(used) >= {1'b0, load_limit});

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = key_reg;
        if (state_reg == S_CLR)
        begin
            wr_en = 1'b1;
            wr_data = '0;
        end
        else if (state_reg == S_EVAL)
        begin
            if (op_reg == OP_ADD && (is_empty || is_del) && !at_limit)
            begin
                wr_en = 1'b1;
            end
            else if (op_reg == OP_REMOVE && !is_empty && is_hit)
            begin
                wr_en = 1'b1;
                wr_data = KEY_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg <= '0;
            steps_reg <= '0;
            live_reg <= '0;
            del_reg <= '0;
            op_reg <= OP_ADD;
            key_reg <= '0;
            st_reg <= ST_ADDED;
            out_valid_reg <= 1'b0;
            cnt_out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    // One slot is emptied per cycle after reset or clear.
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == AW'(SLOTS - 1))
                    begin
                        state_reg <= (op_reg == OP_CLEAR) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        op_reg <= cmd_data.opcode;
                        key_reg <= cmd_data.key;
                        steps_reg <= '0;
                        if (cmd_data.opcode == OP_CLEAR)
                        begin
                            idx_reg <= '0;
                            live_reg <= '0;
                            del_reg <= '0;
                            st_reg <= ST_CLEARED;
                            state_reg <= S_CLR;
                        end
                        else
                        begin
                            idx_reg <= AW'(cmd_data.key[AW-1:0] * HOME_MUL);
                            if (cmd_data.reserved)
                            begin
                                st_reg <= (cmd_data.opcode == OP_ADD) ? ST_RESERVED
                                                                      : ST_NOT_FOUND;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    state_reg <= S_OUT;
                    if (op_reg == OP_ADD)
                    begin
                        if (is_empty || is_del)
                        begin
                            if (at_limit)
                            begin
                                st_reg <= ST_FULL;
                            end
                            else
                            begin
                                st_reg <= ST_ADDED;
                                live_reg <= live_reg + 1'b1;
                                if (is_del && del_reg != '0)
                                begin
                                    del_reg <= del_reg - 1'b1;
                                end
                            end
                        end
                        else if (is_hit)
                        begin
                            st_reg <= ST_PRESENT;
                        end
                        else if (last_step)
                        begin
                            st_reg <= ST_FULL;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        if (is_empty)
                        begin
                            st_reg <= ST_NOT_FOUND;
                        end
                        else if (is_hit)
                        begin
                            if (op_reg == OP_REMOVE)
                            begin
                                st_reg <= ST_REMOVED;
                                if (live_reg != '0)
                                begin
                                    live_reg <= live_reg - 1'b1;
                                end
                                del_reg <= del_reg + 1'b1;
                            end
                            else
                            begin
                                st_reg <= ST_MEMBER;
                            end
                        end
                        else if (last_step)
                        begin
                            st_reg <= ST_NOT_FOUND;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                    if (state_reg == S_EVAL)
                    begin
                        idx_reg <= idx_reg + STRIDE;
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    cnt_out_reg <= 11'(live_reg);
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, live_reg} + {1'b0, del_reg} <= (CW+1)'(SLOTS))
        else $error("slot counts exceed table size");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !cmd_ready)
        else $error("command taken while busy");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |=> out_valid_reg)
        else $error("result not presented");
`endif
endmodule

FILE: sim/open_addressing_hash_set_test.sv
`timescale 1ns / 1ps
module open_addressing_hash_set_test;
    import oahs_pkg::*;

    localparam int NSLOTS = 1024;
    localparam int SLOT_MSK = NSLOTS - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [10:0] cfg_data = '0;

    open_addressing_hash_set dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // Shadow copy of the set.
    logic [47:0] shadow_slots [NSLOTS];
    int unsigned shadow_live;
    int unsigned shadow_deleted;
    int unsigned shadow_limit;

    in_item_t pending_ops [$];
    out_item_t expected_answers [$];
    logic [47:0] used_keys [$];
    int errors = 0;
    bit hold_off = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic int home_of(logic [47:0] k);
        logic [47:0] p;
        p = k * 48'd73;
        return int'(p[9:0]);
    endfunction

    function automatic int next_of(int i);
        return (i + 5009) & SLOT_MSK;
    endfunction

    function automatic void shadow_clear();
        for (int i = 0; i < NSLOTS; i++) shadow_slots[i] = '0;
        shadow_live = 0;
        shadow_deleted = 0;
    endfunction

    function automatic out_item_t apply_op(in_item_t op);
        out_item_t r;
        int idx;
        logic [2:0] st;
        bit fin;
        idx = home_of(op.key);
        fin = 1'b0;
        st = ST_NOT_FOUND;
        if (op.opcode == OP_CLEAR) begin
            shadow_clear();
            st = ST_CLEARED;
        end else if (op.key <= 48'd1) begin
            st = (op.opcode == OP_ADD) ? ST_RESERVED : ST_NOT_FOUND;
        end else if (op.opcode == OP_ADD) begin
            st = ST_FULL;
            for (int n = 0; n < NSLOTS && !fin; n++) begin
                if (shadow_slots[idx] <= 48'd1) begin
                    fin = 1'b1;
                    if (shadow_live + shadow_deleted < shadow_limit) begin
                        if (shadow_slots[idx] == 48'd1 && shadow_deleted > 0)
                            shadow_deleted--;
                        shadow_slots[idx] = op.key;
                        shadow_live++;
                        st = ST_ADDED;
                    end
                end else if (shadow_slots[idx] == op.key) begin
                    fin = 1'b1;
                    st = ST_PRESENT;
                end
                idx = next_of(idx);
            end
        end else begin
            for (int n = 0; n < NSLOTS && !fin; n++) begin
                if (shadow_slots[idx] == 48'd0) begin
                    fin = 1'b1;
                end else if (shadow_slots[idx] == op.key) begin
                    fin = 1'b1;
                    if (op.opcode == OP_REMOVE) begin
                        shadow_slots[idx] = 48'd1;
                        if (shadow_live > 0) shadow_live--;
                        shadow_deleted++;
                        st = ST_REMOVED;
                    end else begin
                        st = ST_MEMBER;
                    end
                end else begin
                    idx = next_of(idx);
                end
            end
        end
        r.status = st;
        r.item_count = shadow_live[10:0];
        return r;
    endfunction

    // Driver: bursts with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_answers.push_back(apply_op(in_data));
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    in_data <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(30, 1);
                        gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 0);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    int stall_phase = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_answers.size() == 0) begin
                    $error("unexpected transfer: status %0d item_count %0d",
                        out_data.status, out_data.item_count);
                    errors++;
                end else begin
                    out_item_t e;
                    e = expected_answers.pop_front();
                    if (out_data.status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, out_data.status);
                        errors++;
                    end
                    if (out_data.item_count !== e.item_count) begin
                        $error("item_count: expected %0d, actual %0d",
                            e.item_count, out_data.item_count);
                        errors++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 23;
            if (hold_off) out_ready <= 1'b0;
            else if (stall_phase < 8) out_ready <= 1'b1;
            else out_ready <= ($urandom_range(3, 0) != 0);
        end
    end

    function automatic logic [47:0] rand_key();
        logic [47:0] k;
        int c;
        c = $urandom_range(9, 0);
        k = 48'({$urandom, $urandom});
        if (c < 5 && used_keys.size() > 0)
            k = used_keys[$urandom_range(used_keys.size() - 1, 0)];
        else if (c == 5)
            k = 48'($urandom_range(1, 0));
        else if (c < 8)
            used_keys.push_back(k);
        return k;
    endfunction

    task automatic queue_op(logic [1:0] opc, logic [47:0] k);
        in_item_t it;
        it.opcode = opc;
        it.key = k;
        pending_ops.push_back(it);
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (2 * NSLOTS + 50) @(posedge clk);
    endtask

    task automatic write_limit(int unsigned lim);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= lim[10:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_limit = lim;
    endtask

    task automatic random_phase(int count, int add_weight);
        for (int i = 0; i < count; i++) begin
            int r;
            r = $urandom_range(99, 0);
            if (r < add_weight) queue_op(OP_ADD, rand_key());
            else if (r < add_weight + 20) queue_op(OP_REMOVE, rand_key());
            else if (r < 98) queue_op(OP_MEMBER, rand_key());
            else queue_op(OP_CLEAR, 48'({$urandom, $urandom}));
        end
    endtask

    initial begin
        shadow_clear();
        shadow_limit = 870;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2 * NSLOTS + 20) @(posedge clk);

        // Directed: reserved keys, extremes, colliding keys, tombstone reuse.
        queue_op(OP_ADD, 48'd0);
        queue_op(OP_ADD, 48'd1);
        queue_op(OP_REMOVE, 48'd1);
        queue_op(OP_MEMBER, 48'd0);
        queue_op(OP_ADD, 48'hFFFF_FFFF_FFFF);
        queue_op(OP_ADD, 48'hFFFF_FFFF_FFFF);
        queue_op(OP_ADD, 48'd2);
        queue_op(OP_ADD, 48'd2 + 48'd1024);
        queue_op(OP_ADD, 48'd2 + 48'd2048);
        queue_op(OP_REMOVE, 48'd2 + 48'd1024);
        queue_op(OP_MEMBER, 48'd2 + 48'd2048);
        queue_op(OP_MEMBER, 48'd2 + 48'd1024);
        queue_op(OP_ADD, 48'd2 + 48'd3072);
        queue_op(OP_REMOVE, 48'hFFFF_FFFF_FFFF);
        queue_op(OP_REMOVE, 48'hFFFF_FFFF_FFFF);
        queue_op(OP_MEMBER, 48'hAAAA_5555_AAAA);
        queue_op(OP_CLEAR, 48'h5555_AAAA_5555);
        queue_op(OP_MEMBER, 48'd2);
        drain();

        // Limit of one: a second key is refused, a present one still answers.
        write_limit(1);
        queue_op(OP_ADD, 48'h1234);
        queue_op(OP_ADD, 48'h5678);
        queue_op(OP_ADD, 48'h1234);
        queue_op(OP_REMOVE, 48'h1234);
        queue_op(OP_ADD, 48'h1234);
        random_phase(60, 50);
        drain();

        // Zero refuses every new key.
        write_limit(0);
        queue_op(OP_CLEAR, 48'd0);
        random_phase(20, 60);
        drain();

        // Hold off the receiver while the sender keeps offering transfers.
        write_limit(870);
        queue_op(OP_CLEAR, 48'd0);
        random_phase(40, 60);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
        random_phase(250, 45);
        drain();

        // Small limit, with many tombstones and refusals.
        write_limit(24);
        random_phase(200, 50);
        drain();

        // Largest limit; after a clear, add many random keys.
        write_limit(2047);
        queue_op(OP_CLEAR, 48'd0);
        for (int i = 0; i < 60; i++) queue_op(OP_ADD, 48'({$urandom, $urandom}));
        random_phase(170, 55);
        drain();

        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: open_addressing_hash_set.f
design/oahs_pkg.sv
design/oahs_front.sv
design/oahs_back.sv
design/open_addressing_hash_set.sv
sim/open_addressing_hash_set_test.sv
